>>> rtl/crt_pg_pkg.sv
// Shared types and constants for the CRT palette generator pipeline.
package crt_pg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Reciprocal multipliers for the constant divisions (exact over the value ranges used)
  localparam logic [20:0] RCP1000    = 21'd1073742;
  localparam int          RCP1000_SH = 30;
  localparam logic [19:0] RCP255     = 20'd526345;
  localparam int          RCP255_SH  = 27;
  localparam logic [7:0]  RCP3       = 8'd171;
  localparam int          RCP3_SH    = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE    = 3'd0,
    CFG_GHOST    = 3'd1,
    CFG_SCANLINE = 3'd2,
    CFG_BRIGHT   = 3'd3,
    CFG_CONTRAST = 3'd4,
    CFG_SAT      = 3'd5,
    CFG_MODE     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [5:0] noise;
    logic signed [6:0] ghost;
    logic signed [6:0] scanline;
    logic [7:0]        bright;
    logic [7:0]        contrast;
    logic [7:0]        sat;
    logic [2:0]        mode;   // bit0 vibrant, bit1 artifacts, bit2 inverse
  } cfg_t;

  // Per-item fields carried through the front stages
  typedef struct packed {
    logic [3:0]         col;
    logic               scan;
    logic signed [11:0] bl;
    logic signed [11:0] on;
    logic signed [7:0]  off;
  } ctl_t;

  typedef struct packed {
    logic       valid;
    ctl_t       ctl;
    logic [9:0] basec;
  } front_t;

  typedef struct packed {
    logic               valid;
    logic               scan;
    logic signed [7:0]  off;
    logic signed [11:0] bw;
    logic signed [11:0] qr;
    logic signed [11:0] qg;
    logic signed [11:0] qb;
  } mix_t;

endpackage

>>> rtl/crt_pg_front.sv
// Front stages: colour decode, levels, variant offset and base colour step.
module crt_pg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_index,
  input  crt_pg_pkg::cfg_t  cfg,
  output crt_pg_pkg::front_t front_o
);
  import crt_pg_pkg::*;

  logic        s1_valid_r, s2_valid_r, s3_valid_r;
  ctl_t        s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [15:0] s1_diff_r;
  logic [19:0] s2_prod_r;
  logic [9:0]  s3_basec_r;

  ctl_t        s1_ctl_nxt;
  logic [15:0] s1_diff_nxt;
  logic [19:0] s2_prod_nxt;
  logic [9:0]  s3_basec_nxt;

  logic [3:0]         hue;
  logic [7:0]         cl_u;
  logic signed [11:0] bl, hi, lo;
  logic [9:0]         x;
  logic [16:0]        t125;
  logic signed [7:0]  nl, gl, g3;
  logic [6:0]         gmag;
  logic [14:0]        g3prod;
  logic [4:0]         m3;
  logic [4:0]         fac;
  logic [20:0]        p1;
  logic [40:0]        p2;

  // Stage 1: decode index, derive levels and offset
  always_comb begin
    hue  = in_index[7:4];
    cl_u = ~cfg.contrast;
    bl   = $signed({4'b0, ~cfg.bright}) - $signed({4'b0, cl_u});
    lo   = bl + $signed({3'b0, cl_u, 1'b0});
    hi   = lo + $signed({5'b0, cl_u[7:1]});

    s1_ctl_nxt.col  = cfg.mode[2] ? {hue[3], ~hue[2:0]} : hue;
    s1_ctl_nxt.scan = in_index[3] & cfg.mode[1];
    s1_ctl_nxt.bl   = bl;
    s1_ctl_nxt.on   = hue[3] ? hi : lo;

    x = {1'b0, cl_u, 1'b0} + (s1_ctl_nxt.col[3] ? {3'b0, cl_u[7:1]} : 10'd0);
    // 1000*x/16 = 125*x/2
    t125 = {x, 7'b0} - {6'b0, x, 1'b0} - {7'b0, x};
    s1_diff_nxt = t125[16:1];

    nl   = 8'sd0 - $signed({{2{cfg.noise[5]}}, cfg.noise});
    gl   = 8'sd0 - $signed({cfg.ghost[6], cfg.ghost});
    gmag = gl[7] ? 7'(8'sd0 - gl) : gl[6:0];
    g3prod = gmag * RCP3;
    m3   = g3prod[RCP3_SH+4:RCP3_SH];
    g3   = gl[7] ? (8'sd0 - $signed({3'b0, m3})) : $signed({3'b0, m3});

    case (in_index[2:0])
      3'd0:    s1_ctl_nxt.off = 8'sd0;
      3'd1:    s1_ctl_nxt.off = nl;
      3'd2:    s1_ctl_nxt.off = gl;
      3'd3:    s1_ctl_nxt.off = nl + gl;
      3'd4:    s1_ctl_nxt.off = g3;
      3'd5:    s1_ctl_nxt.off = nl + g3;
      3'd6:    s1_ctl_nxt.off = gl + g3;
      default: s1_ctl_nxt.off = nl + gl;
    endcase
  end

  // Stage 2: scale by the colour step
  always_comb begin
    fac = {2'b0, s1_ctl_r.col[2:0]} + 5'd9;
    p1  = s1_diff_r * fac;
    s2_prod_nxt = p1[19:0];
  end

  // Stage 3: divide by 1000
  always_comb begin
    p2 = s2_prod_r * RCP1000;
    s3_basec_nxt = p2[RCP1000_SH+9:RCP1000_SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r   <= s1_ctl_nxt;
    s1_diff_r  <= s1_diff_nxt;
    s2_ctl_r   <= s1_ctl_r;
    s2_prod_r  <= s2_prod_nxt;
    s3_ctl_r   <= s2_ctl_r;
    s3_basec_r <= s3_basec_nxt;
  end

  assign front_o.valid = s3_valid_r;
  assign front_o.ctl   = s3_ctl_r;
  assign front_o.basec = s3_basec_r;

endmodule

>>> rtl/crt_pg_mix.sv
// Mix stages: channel base values, saturation multiply and divide by 255.
module crt_pg_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  crt_pg_pkg::cfg_t   cfg,
  input  crt_pg_pkg::front_t front_i,
  output crt_pg_pkg::mix_t   mix_o
);
  import crt_pg_pkg::*;

  logic               s4_valid_r, s5_valid_r, s6_valid_r;
  logic               s4_scan_r, s5_scan_r, s6_scan_r;
  logic signed [7:0]  s4_off_r, s5_off_r, s6_off_r;
  logic signed [11:0] s4_bw_r, s5_bw_r, s6_bw_r;
  logic signed [11:0] s4_dr_r, s4_dg_r, s4_db_r;
  logic signed [20:0] s5_pr_r, s5_pg_r, s5_pb_r;
  logic signed [11:0] s6_qr_r, s6_qg_r, s6_qb_r;

  logic signed [11:0] s4_bw_nxt, s4_dr_nxt, s4_dg_nxt, s4_db_nxt;
  logic signed [20:0] s5_pr_nxt, s5_pg_nxt, s5_pb_nxt;

  logic signed [11:0] be, bl, on, cr, cg, cb;
  logic [3:0]         col;
  logic signed [8:0]  mix_s;

  // Truncating signed divide by 255 on magnitude
  function automatic logic signed [11:0] div255(input logic signed [20:0] p);
    logic [19:0] mag;
    logic [39:0] pm;
    logic [10:0] qm;
    mag = p[20] ? 20'(21'sd0 - p) : p[19:0];
    pm  = mag * RCP255;
    qm  = pm[RCP255_SH+10:RCP255_SH];
    return p[20] ? (12'sd0 - $signed({1'b0, qm})) : $signed({1'b0, qm});
  endfunction

  // Stage 4: per-channel colour and difference to the gray level
  always_comb begin
    col = front_i.ctl.col;
    bl  = front_i.ctl.bl;
    on  = front_i.ctl.on;
    be  = (col[2:0] == 3'd0) ? bl : $signed({2'b0, front_i.basec});
    s4_bw_nxt = bl + be;
    if (cfg.mode[0]) begin
      cb = col[0] ? on : bl;
      cg = col[2] ? on : bl;
      cr = col[1] ? on : bl;
    end else begin
      cb = col[0] ? bl + be : bl;
      cg = col[2] ? bl + be : bl;
      cr = col[1] ? bl + be : bl;
    end
    s4_dr_nxt = cr - s4_bw_nxt;
    s4_dg_nxt = cg - s4_bw_nxt;
    s4_db_nxt = cb - s4_bw_nxt;
  end

  // Stage 5: saturation multiply
  always_comb begin
    mix_s = $signed({1'b0, ~cfg.sat});
    s5_pr_nxt = s4_dr_r * mix_s;
    s5_pg_nxt = s4_dg_r * mix_s;
    s5_pb_nxt = s4_db_r * mix_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= front_i.valid;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_scan_r <= front_i.ctl.scan;
    s4_off_r  <= front_i.ctl.off;
    s4_bw_r   <= s4_bw_nxt;
    s4_dr_r   <= s4_dr_nxt;
    s4_dg_r   <= s4_dg_nxt;
    s4_db_r   <= s4_db_nxt;
    s5_scan_r <= s4_scan_r;
    s5_off_r  <= s4_off_r;
    s5_bw_r   <= s4_bw_r;
    s5_pr_r   <= s5_pr_nxt;
    s5_pg_r   <= s5_pg_nxt;
    s5_pb_r   <= s5_pb_nxt;
    s6_scan_r <= s5_scan_r;
    s6_off_r  <= s5_off_r;
    s6_bw_r   <= s5_bw_r;
    s6_qr_r   <= div255(s5_pr_r);
    s6_qg_r   <= div255(s5_pg_r);
    s6_qb_r   <= div255(s5_pb_r);
  end

  assign mix_o.valid = s6_valid_r;
  assign mix_o.scan  = s6_scan_r;
  assign mix_o.off   = s6_off_r;
  assign mix_o.bw    = s6_bw_r;
  assign mix_o.qr    = s6_qr_r;
  assign mix_o.qg    = s6_qg_r;
  assign mix_o.qb    = s6_qb_r;

endmodule

>>> rtl/crt_pg_out.sv
// Output stage: offset, scanline, clamping and packing into RGB565 and RGB888.
module crt_pg_out (
  input  logic              clk,
  input  logic              rst_n,
  input  crt_pg_pkg::cfg_t  cfg,
  input  crt_pg_pkg::mix_t  mix_i,
  output logic              out_strobe,
  output logic [15:0]       out_rgb565,
  output logic [23:0]       out_rgb888
);
  import crt_pg_pkg::*;

  logic        strobe_r;
  logic [15:0] rgb565_r, rgb565_nxt;
  logic [23:0] rgb888_r, rgb888_nxt;

  logic signed [7:0] sl;
  logic [7:0]        r, g, b;

  function automatic logic [7:0] clamp8(input logic signed [13:0] v);
    if (v < 14'sd0) return 8'd0;
    else if (v > 14'sd255) return 8'd255;
    else return v[7:0];
  endfunction

  function automatic logic [7:0] channel(input logic signed [11:0] q,
                                         input logic signed [11:0] bw,
                                         input logic signed [7:0]  off,
                                         input logic               scan,
                                         input logic signed [7:0]  s);
    logic [7:0] c;
    c = clamp8($signed({{2{q[11]}}, q}) + $signed({{2{bw[11]}}, bw})
               + $signed({{6{off[7]}}, off}));
    if (scan) c = clamp8($signed({6'b0, c}) + $signed({{6{s[7]}}, s}));
    return c;
  endfunction

  always_comb begin
    sl = 8'sd0 - $signed({cfg.scanline[6], cfg.scanline});
    r  = channel(mix_i.qr, mix_i.bw, mix_i.off, mix_i.scan, sl);
    g  = channel(mix_i.qg, mix_i.bw, mix_i.off, mix_i.scan, sl);
    b  = channel(mix_i.qb, mix_i.bw, mix_i.off, mix_i.scan, sl);
    rgb565_nxt = {r[7:3], g[7:2], b[7:3]};
    rgb888_nxt = {b, g, r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= mix_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    rgb565_r <= rgb565_nxt;
    rgb888_r <= rgb888_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_rgb565 = rgb565_r;
  assign out_rgb888 = rgb888_r;

`ifndef NO_ASSERTIONS
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (strobe_r == $past(mix_i.valid)))
    else $error("output strobe does not follow the last stage valid");

  a_pack_match: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> (rgb565_r[15:11] == rgb888_r[7:3] && rgb565_r[10:5] == rgb888_r[15:10]
                  && rgb565_r[4:0] == rgb888_r[23:19]))
    else $error("RGB565 and RGB888 disagree");

  a_gray_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $past(mix_i.valid && !mix_i.scan && mix_i.off == 8'sd0 && mix_i.qr == 12'sd0
          && mix_i.bw >= 12'sd0 && mix_i.bw <= 12'sd255)
    |-> (rgb888_r[7:0] == $past(mix_i.bw[7:0])))
    else $error("red channel lost the gray level with no offset");
`endif

endmodule

>>> rtl/crt_palette_generator_top.sv
// Pipeline: 7 registers (6 pipeline stages + output reg); an accepted item passes stages
//   s1 to s6 in order, and the output reg raises the strobe together with its result.
// Throughput: one item per clock; busy stays low and the pipeline never stalls.
// Stage depth is set by the multiply stages (color step, /1000, saturation, /255).
// Reset (synchronous, active low) clears all configuration registers to zero
// and drops any items in flight.
module crt_palette_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       in_palette_index,
  input  logic                             cfg_we,
  input  logic [crt_pg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crt_pg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                             out_strobe,
  output logic [15:0]                      out_rgb565,
  output logic [23:0]                      out_rgb888
);
  import crt_pg_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  front_t front;
  mix_t   mix;
  logic   in_valid;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  // Register write decode; writes to unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NOISE:    cfg_nxt.noise    = cfg_data[5:0];
        CFG_GHOST:    cfg_nxt.ghost    = cfg_data[6:0];
        CFG_SCANLINE: cfg_nxt.scanline = cfg_data[6:0];
        CFG_BRIGHT:   cfg_nxt.bright   = cfg_data;
        CFG_CONTRAST: cfg_nxt.contrast = cfg_data;
        CFG_SAT:      cfg_nxt.sat      = cfg_data;
        CFG_MODE:     cfg_nxt.mode     = cfg_data[2:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crt_pg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_index (in_palette_index),
    .cfg      (cfg_r),
    .front_o  (front)
  );

  crt_pg_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .front_i (front),
    .mix_o   (mix)
  );

  crt_pg_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .mix_i      (mix),
    .out_strobe (out_strobe),
    .out_rgb565 (out_rgb565),
    .out_rgb888 (out_rgb888)
  );

endmodule

>>> test/crt_palette_checker.sv
`timescale 1ns / 1ps
// Checker for the CRT palette generator: tracks register writes, predicts colors, compares.
module crt_palette_checker
  import crt_pg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [7:0]           in_palette_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 out_strobe,
  input  logic [15:0]          out_rgb565,
  input  logic [23:0]          out_rgb888,
  output int                   errors,
  output int                   pending
);

  // Mode flag bit positions
  localparam int MODE_VIBRANT   = 0;
  localparam int MODE_ARTIFACTS = 1;
  localparam int MODE_INVERSE   = 2;

  // Effect variants in index bits 2..0
  localparam logic [2:0] FX_NONE         = 3'd0;
  localparam logic [2:0] FX_NOISE        = 3'd1;
  localparam logic [2:0] FX_GHOST        = 3'd2;
  localparam logic [2:0] FX_NOISE_GHOST  = 3'd3;
  localparam logic [2:0] FX_GHOST3       = 3'd4;
  localparam logic [2:0] FX_NOISE_GHOST3 = 3'd5;
  localparam logic [2:0] FX_GHOST_GHOST3 = 3'd6;

  typedef struct packed {
    logic [15:0] rgb565;
    logic [23:0] rgb888;
  } color_t;

  cfg_t   regs;
  color_t expected_colors[$];
  color_t want;

  function automatic int clamp_channel(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic color_t palette_color(input logic [7:0] idx, input cfg_t c);
    int hue, col, nl, gl, g3, sl, cl, bl, hi, lo, mix;
    int diff, basec, on_lvl, cr, cg, cb, bw, r, g, b, off;
    logic [7:0] r8, g8, b8;
    color_t res;
    hue = int'(idx[7:4]);
    nl  = -int'(c.noise);
    gl  = -int'(c.ghost);
    g3  = gl / 3;
    sl  = -int'(c.scanline);
    cl  = 255 - int'(c.contrast);
    bl  = (255 - int'(c.bright)) - cl;
    hi  = bl + cl / 2 + 2 * cl;
    lo  = bl + 2 * cl;
    mix = 255 - int'(c.sat);

    // inverse video mirrors the color within its half
    col = c.mode[MODE_INVERSE] ? (hue & 8) + (7 - (hue & 7)) : hue;

    diff  = (1000 * ((col > 7 ? hi : lo) - bl)) / 16;
    basec = (diff * ((col & 7) + 9)) / 1000;
    if (col == 0 || col == 8) basec = bl;

    // the vibrant level follows the raw hue, not the inverted one
    on_lvl = (hue > 7) ? hi : lo;
    if (c.mode[MODE_VIBRANT]) begin
      cb = (col & 1) ? on_lvl : bl;
      cg = (col & 4) ? on_lvl : bl;
      cr = (col & 2) ? on_lvl : bl;
    end else begin
      cb = bl + ((col & 1) ? basec : 0);
      cg = bl + ((col & 4) ? basec : 0);
      cr = bl + ((col & 2) ? basec : 0);
    end
    bw = bl + basec;
    r  = ((cr - bw) * mix) / 255 + bw;
    g  = ((cg - bw) * mix) / 255 + bw;
    b  = ((cb - bw) * mix) / 255 + bw;

    case (idx[2:0])
      FX_NONE:         off = 0;
      FX_NOISE:        off = nl;
      FX_GHOST:        off = gl;
      FX_NOISE_GHOST:  off = nl + gl;
      FX_GHOST3:       off = g3;
      FX_NOISE_GHOST3: off = nl + g3;
      FX_GHOST_GHOST3: off = gl + g3;
      default:         off = nl + gl;
    endcase
    r = clamp_channel(r + off);
    g = clamp_channel(g + off);
    b = clamp_channel(b + off);

    if (idx[3] && c.mode[MODE_ARTIFACTS]) begin
      r = clamp_channel(r + sl);
      g = clamp_channel(g + sl);
      b = clamp_channel(b + sl);
    end

    r8 = r[7:0];
    g8 = g[7:0];
    b8 = b[7:0];
    res.rgb565 = {r8[7:3], g8[7:2], b8[7:3]};
    res.rgb888 = {b8, g8, r8};
    return res;
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '0;
      expected_colors.delete();
    end else begin
      if (out_strobe) begin
        if (expected_colors.size() == 0) begin
          report($sformatf("unexpected result rgb565=%h rgb888=%h", out_rgb565, out_rgb888));
        end else begin
          want = expected_colors.pop_front();
          if (out_rgb565 !== want.rgb565)
            report($sformatf("rgb565 got %h expected %h", out_rgb565, want.rgb565));
          if (out_rgb888 !== want.rgb888)
            report($sformatf("rgb888 got %h expected %h", out_rgb888, want.rgb888));
        end
      end
      if (start && !busy)
        expected_colors.push_back(palette_color(in_palette_index, regs));
      if (cfg_we) begin
        case (cfg_index)
          CFG_NOISE:    regs.noise    = cfg_data[5:0];
          CFG_GHOST:    regs.ghost    = cfg_data[6:0];
          CFG_SCANLINE: regs.scanline = cfg_data[6:0];
          CFG_BRIGHT:   regs.bright   = cfg_data;
          CFG_CONTRAST: regs.contrast = cfg_data;
          CFG_SAT:      regs.sat      = cfg_data;
          CFG_MODE:     regs.mode     = cfg_data[2:0];
          default: ;
        endcase
      end
    end
    pending = expected_colors.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the CRT palette generator: stimulus, register setup and verdict.
module tb;
  import crt_pg_pkg::*;

  localparam int LATENCY      = 7;
  localparam int DRAIN_CYCLES = LATENCY + 5;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 95;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // unmapped, writes are dropped

  localparam logic [7:0] MODE_VIBRANT   = 8'd1;
  localparam logic [7:0] MODE_ARTIFACTS = 8'd2;
  localparam logic [7:0] MODE_INVERSE   = 8'd4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [7:0]            in_palette_index;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_strobe;
  logic [15:0]           out_rgb565;
  logic [23:0]           out_rgb888;
  int                    errors;
  int                    pending;
  int                    idle_pct;
  int                    sent;

  always #1 clk = ~clk;

  crt_palette_generator_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_palette_index (in_palette_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_rgb565       (out_rgb565),
    .out_rgb888       (out_rgb888)
  );

  crt_palette_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_palette_index (in_palette_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_rgb565       (out_rgb565),
    .out_rgb888       (out_rgb888),
    .errors           (errors),
    .pending          (pending)
  );

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] noise, ghost, scan, bright, contr, sat, mode);
    write_reg(CFG_SPARE, 8'($urandom));
    write_reg(CFG_NOISE, noise);
    write_reg(CFG_GHOST, ghost);
    write_reg(CFG_SCANLINE, scan);
    write_reg(CFG_BRIGHT, bright);
    write_reg(CFG_CONTRAST, contr);
    write_reg(CFG_SAT, sat);
    write_reg(CFG_MODE, mode);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every item has come back, then let the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start            <= 1'b0;
      in_palette_index <= 8'($urandom);
      @(posedge clk);
    end
    start            <= 1'b1;
    in_palette_index <= idx;
    // busy only moves at the rising edge, so its value at the falling edge decides acceptance
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly in range, sometimes a raw byte that exercises the sign bits.
  function automatic logic [7:0] rand_signed(input int lim);
    int v;
    if ($urandom_range(3) == 0) return 8'($urandom);
    v = int'($urandom_range(2 * lim)) - lim;
    return v[7:0];
  endfunction

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_palette_index <= 8'd0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_NOISE;
    cfg_data         <= 8'd0;
    idle_pct = 0;
    sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, corner indexes
    send_item(8'h00);
    send_item(8'hFF);
    send_item(8'h88);
    send_item(8'h7F);
    drain();

    // all modes on: every color, every variant, both scanline halves
    write_config(8'hEC, 8'hD8, 8'h28, 8'd100, 8'd160, 8'd64,
                 MODE_VIBRANT | MODE_ARTIFACTS | MODE_INVERSE);
    for (int c = 0; c < 16; c++) send_item(8'(c * 17));
    drain();

    // register extremes, levels pushed to the rails
    write_config(8'h14, 8'h28, 8'hD8, 8'd255, 8'd255, 8'd255, MODE_VIBRANT | MODE_ARTIFACTS);
    send_item(8'h0F);
    send_item(8'hF8);
    send_item(8'h83);
    send_item(8'h7C);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else if (p == 1)
        write_config(8'h20, 8'h40, 8'h40, 8'h00, 8'h00, 8'h00, MODE_ARTIFACTS);
      else
        write_config(rand_signed(20), rand_signed(40), rand_signed(40), 8'($urandom),
                     8'($urandom), 8'($urandom),
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (sent < 317)      idle_pct = 33;
        else if (sent < 634) idle_pct = 72;
        else                 idle_pct = 0;
        send_item(8'($urandom));
        sent++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/crt_pg_pkg.sv
rtl/crt_pg_front.sv
rtl/crt_pg_mix.sv
rtl/crt_pg_out.sv
rtl/crt_palette_generator_top.sv
test/crt_palette_checker.sv
test/tb.sv
